// ===== rtl/srrip_pkg.sv =====
package srrip_pkg;

	localparam int unsigned ADDR_BITS = 32;
	localparam int unsigned TAG_BITS = 32;
	localparam int unsigned MAX_INDEX_BITS = 10;
	localparam int unsigned MAX_OFFSET_BITS = 6;
	localparam int unsigned CFG_DATA_BITS = 5;
	localparam int unsigned CFG_INDEX_BITS = 2;
	localparam int unsigned CNT_BITS = 32;

	localparam int unsigned DEF_MAX_WAYS = 16;
	localparam int unsigned DEF_MAX_SETS = 1024;

	localparam logic [CFG_INDEX_BITS-1:0] REG_OFFSET_BITS = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_INDEX_BITS = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WAYS_USED = 2'd2;

	localparam logic [2:0] RST_OFFSET_BITS = 3'd5;
	localparam logic [3:0] RST_INDEX_BITS = 4'd6;
	localparam logic [4:0] RST_WAYS_USED = 5'd4;

	localparam logic [1:0] RRPV_FILL = 2'd2;
	localparam logic [1:0] RRPV_MAX = 2'd3;
	localparam logic [1:0] RRPV_HIT = 2'd0;

	typedef struct packed {
		logic [ADDR_BITS-1:0] address;
		logic                 operation;
	} in_t;

	typedef struct packed {
		logic                hit;
		logic                dirty_eviction;
		logic [3:0]          way_used;
		logic [CNT_BITS-1:0] load_hit_count;
		logic [CNT_BITS-1:0] load_miss_count;
		logic [CNT_BITS-1:0] store_hit_count;
		logic [CNT_BITS-1:0] store_miss_count;
		logic [CNT_BITS-1:0] dirty_eviction_count;
	} out_t;

	typedef struct packed {
		logic [2:0] offset_bits;
		logic [3:0] index_bits;
		logic [4:0] ways_used;
	} cfg_t;

endpackage

// ===== rtl/srrip_set_assoc_cache_lookup.sv =====
// channel  | beat ports                        | handshake
// input    | item (address, operation)         | push / full
// result   | result (hit .. counts)            | pop / empty
// config   | register_index, write_data        | write_enable
// Front registers an item and, when the set number is not below MAX_SETS, reduces
// it modulo MAX_SETS first; back reads the set row into a register and writes it
// back once the result can be taken. Front and back each take a new item only after the last.
// After reset the tag store is cleared, one set per cycle; full stays high
// until then. A held result stalls the back; a 2-beat queue lets the front
// run ahead.
module srrip_set_assoc_cache_lookup #(
	parameter int unsigned MAX_WAYS = srrip_pkg::DEF_MAX_WAYS,
	parameter int unsigned MAX_SETS = srrip_pkg::DEF_MAX_SETS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  srrip_pkg::in_t                        item,
	input  logic                                  pop,
	output logic                                  empty,
	output srrip_pkg::out_t                       result,
	input  logic                                  write_enable,
	input  logic [srrip_pkg::CFG_INDEX_BITS-1:0]  register_index,
	input  logic [srrip_pkg::CFG_DATA_BITS-1:0]   write_data
);
	localparam int unsigned SET_AW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int unsigned QW = SET_AW + srrip_pkg::TAG_BITS + 1;

	srrip_pkg::cfg_t cfg_q;
	logic            busy, clearing, q_wr, q_full, q_rd, q_empty, res_valid;
	logic [QW-1:0]   q_in, q_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.offset_bits <= srrip_pkg::RST_OFFSET_BITS;
			cfg_q.index_bits <= srrip_pkg::RST_INDEX_BITS;
			cfg_q.ways_used <= srrip_pkg::RST_WAYS_USED;
		end else if (write_enable) begin
			priority case (register_index)
				srrip_pkg::REG_OFFSET_BITS: cfg_q.offset_bits <= write_data[2:0];
				srrip_pkg::REG_INDEX_BITS: cfg_q.index_bits <= write_data[3:0];
				srrip_pkg::REG_WAYS_USED: cfg_q.ways_used <= write_data;
				default: ;
			endcase
		end
	end

	assign full = busy || clearing;
	assign empty = !res_valid;

	srrip_front #(.MAX_SETS(MAX_SETS), .SET_AW(SET_AW)) u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .push(push && !clearing), .item(item),
		.busy(busy), .q_wr(q_wr), .q_data(q_in), .q_full(q_full)
	);

	srrip_fifo #(.WIDTH(QW)) u_fifo (
		.clk(clk), .arst_n(arst_n), .wr(q_wr), .wdata(q_in), .full(q_full),
		.rd(q_rd), .rdata(q_out), .empty(q_empty)
	);

	srrip_back #(.MAX_WAYS(MAX_WAYS), .MAX_SETS(MAX_SETS), .SET_AW(SET_AW)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .q_empty(q_empty), .q_data(q_out),
		.q_rd(q_rd), .clearing(clearing), .res_valid(res_valid), .res(result),
		.res_pop(pop)
	);

	a_no_take_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !q_rd) else $error("queue read during clear");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr |-> !q_full) else $error("queue overflow");
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !pop) |=> res_valid && $stable(result))
		else $error("result lost");
endmodule

// ===== rtl/srrip_fifo.sv =====
module srrip_fifo #(
	parameter int unsigned WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	logic [WIDTH-1:0] mem_q [2];
	logic             wp_q, rp_q;
	logic [1:0]       cnt_q;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr && !full) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr && !full) wp_q <= !wp_q;
			if (rd && !empty) rp_q <= !rp_q;
			if ((wr && !full) && !(rd && !empty)) cnt_q <= cnt_q + 2'd1;
			else if (!(wr && !full) && (rd && !empty)) cnt_q <= cnt_q - 2'd1;
		end
	end
endmodule

// ===== rtl/srrip_front.sv =====
module srrip_front #(
	parameter int unsigned MAX_SETS = srrip_pkg::DEF_MAX_SETS,
	parameter int unsigned SET_AW = 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  srrip_pkg::cfg_t          cfg,
	input  logic                     push,
	input  srrip_pkg::in_t           item,
	output logic                     busy,
	output logic                     q_wr,
	output logic [SET_AW+srrip_pkg::TAG_BITS:0] q_data,
	input  logic                     q_full
);
	localparam int unsigned IW = srrip_pkg::MAX_INDEX_BITS;
	localparam int unsigned RB = 2 * IW;
	localparam int unsigned PW = RB + IW + 1;
	localparam logic [PW-1:0] RECIP =
		PW'(((64'd1 << RB) + 64'(MAX_SETS) - 64'd1) / 64'(MAX_SETS));

	logic          v_s1, mod_q;
	logic [IW-1:0] rem_s1;
	logic [srrip_pkg::TAG_BITS-1:0] tag_s1;
	logic          st_s1;

	logic [2:0]    ob;
	logic [3:0]    ib;
	logic [4:0]    sh;
	logic [IW-1:0] set_raw;
	logic [PW-1:0] prod;
	logic [IW-1:0] quo;

	always_comb begin
		ob = (cfg.offset_bits > 3'(srrip_pkg::MAX_OFFSET_BITS)) ?
			3'(srrip_pkg::MAX_OFFSET_BITS) : cfg.offset_bits;
		ib = (cfg.index_bits > 4'(IW)) ? 4'(IW) : cfg.index_bits;
		sh = 5'(ob) + 5'(ib);
		set_raw = IW'(item.address >> ob) & IW'((11'd1 << ib) - 11'd1);
		prod = PW'(rem_s1) * RECIP;
		quo = IW'(prod >> RB);
	end

	assign busy = v_s1;
	assign q_wr = v_s1 && !mod_q && !q_full;
	assign q_data = {SET_AW'(rem_s1), tag_s1, st_s1};

	always_ff @(posedge clk) begin
		if (push && !v_s1) begin
			rem_s1 <= set_raw;
			tag_s1 <= srrip_pkg::TAG_BITS'(item.address >> sh);
			st_s1 <= item.operation;
		end else if (mod_q) begin
			rem_s1 <= rem_s1 - IW'(32'(quo) * MAX_SETS);
		end
	end

	// reciprocal multiply, set number reduced modulo MAX_SETS while mod_q is set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			mod_q <= 1'b0;
		end else begin
			if (push && !v_s1) begin
				v_s1 <= 1'b1;
				mod_q <= (32'(set_raw) >= 32'(MAX_SETS));
			end else if (mod_q) begin
				mod_q <= 1'b0;
			end else if (q_wr) begin
				v_s1 <= 1'b0;
			end
		end
	end
endmodule

// ===== rtl/srrip_back.sv =====
module srrip_back #(
	parameter int unsigned MAX_WAYS = srrip_pkg::DEF_MAX_WAYS,
	parameter int unsigned MAX_SETS = srrip_pkg::DEF_MAX_SETS,
	parameter int unsigned SET_AW = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  srrip_pkg::cfg_t      cfg,
	input  logic                 q_empty,
	input  logic [SET_AW+srrip_pkg::TAG_BITS:0] q_data,
	output logic                 q_rd,
	output logic                 clearing,
	output logic                 res_valid,
	output srrip_pkg::out_t      res,
	input  logic                 res_pop
);
	localparam int unsigned TW = srrip_pkg::TAG_BITS;
	localparam int unsigned EW = TW + 4;
	localparam int unsigned RW = EW * MAX_WAYS;
	localparam int unsigned WW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int unsigned CW = srrip_pkg::CNT_BITS;
	localparam logic [1:0] ST_CLR = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_EVAL = 2'd2;

	logic [RW-1:0]     mem [MAX_SETS];
	logic [RW-1:0]     row_q;
	logic [1:0]        state_q;
	logic [SET_AW-1:0] clr_q, set_q;
	logic [TW-1:0]     tag_q;
	logic              st_q;
	logic [CW-1:0]     lh_q, lm_q, sh_q, sm_q, de_q;

	logic [5:0]        nw;
	logic              found, hitw, dev, commit, we;
	logic [WW-1:0]     sel;
	logic [1:0]        mx;
	logic [RW-1:0]     new_row;
	logic [SET_AW-1:0] waddr;
	logic [CW-1:0]     lh_n, lm_n, sh_n, sm_n, de_n;

	function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v, input logic en);
		sat_inc = (en && v != '1) ? v + CW'(1) : v;
	endfunction

	// entry: valid, dirty, rrpv[1:0], tag
	always_comb begin
		nw = (cfg.ways_used == 5'd0) ? 6'd1 :
			((32'(cfg.ways_used) > 32'(MAX_WAYS)) ? 6'(MAX_WAYS) : 6'(cfg.ways_used));
		found = 1'b0;
		hitw = 1'b0;
		sel = '0;
		mx = 2'd0;
		new_row = row_q;
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (6'(w) < nw && !found &&
			    (!row_q[w*EW+TW+3] || row_q[w*EW +: TW] == tag_q)) begin
				found = 1'b1;
				hitw = row_q[w*EW+TW+3];
				sel = WW'(w);
			end
			if (6'(w) < nw && row_q[w*EW+TW +: 2] > mx) mx = row_q[w*EW+TW +: 2];
		end
		if (!found) begin
			for (int w = MAX_WAYS - 1; w >= 0; w--) begin
				if (6'(w) < nw) begin
					if (row_q[w*EW+TW +: 2] == mx) sel = WW'(w);
					new_row[w*EW+TW +: 2] = row_q[w*EW+TW +: 2] + (srrip_pkg::RRPV_MAX - mx);
				end
			end
		end
		dev = !found && row_q[32'(sel)*EW+TW+2];
		if (hitw) begin
			new_row[32'(sel)*EW+TW +: 2] = srrip_pkg::RRPV_HIT;
			if (st_q) new_row[32'(sel)*EW+TW+2] = 1'b1;
		end else begin
			new_row[32'(sel)*EW +: EW] = {1'b1, st_q, srrip_pkg::RRPV_FILL, tag_q};
		end
		commit = (state_q == ST_EVAL) && (!res_valid || res_pop);
		q_rd = (state_q == ST_IDLE) && !q_empty;
		we = commit || (state_q == ST_CLR);
		waddr = (state_q == ST_CLR) ? clr_q : set_q;
		lh_n = sat_inc(lh_q, hitw && !st_q);
		lm_n = sat_inc(lm_q, !hitw && !st_q);
		sh_n = sat_inc(sh_q, hitw && st_q);
		sm_n = sat_inc(sm_q, !hitw && st_q);
		de_n = sat_inc(de_q, dev);
	end

	assign clearing = (state_q == ST_CLR);

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= clearing ? '0 : new_row;
		if (q_rd) row_q <= mem[q_data[TW+1 +: SET_AW]];
	end

	always_ff @(posedge clk) begin
		if (q_rd) {set_q, tag_q, st_q} <= q_data;
		if (commit) begin
			res.hit <= hitw;
			res.dirty_eviction <= dev;
			res.way_used <= 4'(sel);
			res.load_hit_count <= lh_n;
			res.load_miss_count <= lm_n;
			res.store_hit_count <= sh_n;
			res.store_miss_count <= sm_n;
			res.dirty_eviction_count <= de_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q <= '0;
			res_valid <= 1'b0;
			lh_q <= '0;
			lm_q <= '0;
			sh_q <= '0;
			sm_q <= '0;
			de_q <= '0;
		end else begin
			if (commit) begin
				res_valid <= 1'b1;
				lh_q <= lh_n;
				lm_q <= lm_n;
				sh_q <= sh_n;
				sm_q <= sm_n;
				de_q <= de_n;
			end else if (res_pop) begin
				res_valid <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + SET_AW'(1);
					if (clr_q == SET_AW'(MAX_SETS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (q_rd) state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (commit) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== tb/sv/tb_srrip_set_assoc_cache_lookup.sv =====
module tb_srrip_set_assoc_cache_lookup;
	import srrip_pkg::*;

	class lookup_scoreboard;
		bit          line_vld [16384];
		logic [31:0] line_tg  [16384];
		bit   [1:0]  line_rr  [16384];
		bit          line_dt  [16384];
		logic [31:0] n_ld_hit, n_ld_miss, n_st_hit, n_st_miss, n_dirty_ev;
		logic [2:0]  offset_reg;
		logic [3:0]  index_reg;
		logic [4:0]  ways_reg;
		out_t        expected_q[$];
		int          errors;
		int          checked;

		function new();
			foreach (line_vld[i]) line_vld[i] = 0;
			n_ld_hit = 0; n_ld_miss = 0; n_st_hit = 0; n_st_miss = 0; n_dirty_ev = 0;
			offset_reg = RST_OFFSET_BITS;
			index_reg = RST_INDEX_BITS;
			ways_reg = RST_WAYS_USED;
			errors = 0;
			checked = 0;
		endfunction

		function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [4:0] val);
			case (idx)
				REG_OFFSET_BITS: offset_reg = val[2:0];
				REG_INDEX_BITS: index_reg = val[3:0];
				REG_WAYS_USED: ways_reg = val;
				default: ;
			endcase
		endfunction

		function int unsigned eff_offset();
			return (offset_reg > 6) ? 6 : offset_reg;
		endfunction

		function int unsigned eff_index();
			return (index_reg > 10) ? 10 : index_reg;
		endfunction

		function int unsigned eff_ways();
			return (ways_reg == 0) ? 1 : ((ways_reg > 16) ? 16 : ways_reg);
		endfunction

		function logic [31:0] sat_inc(logic [31:0] v);
			return (v == 32'hFFFF_FFFF) ? v : v + 1;
		endfunction

		function void fill(int unsigned slot, logic [31:0] tg, bit st);
			line_vld[slot] = 1;
			line_tg[slot] = tg;
			line_rr[slot] = RRPV_FILL;
			line_dt[slot] = st;
		endfunction

		function void note_access(in_t it);
			int unsigned ob, ib, nw, set_no, base, w, way;
			logic [31:0] tg;
			bit hit, done, dev;
			out_t e;
			ob = eff_offset();
			ib = eff_index();
			nw = eff_ways();
			set_no = (it.address >> ob) & ((32'd1 << ib) - 1);
			set_no = set_no % DEF_MAX_SETS;
			tg = it.address >> (ob + ib);
			base = set_no * DEF_MAX_WAYS;
			hit = 0; done = 0; dev = 0; way = 0;
			for (w = 0; w < nw && !done; w++) begin
				if (!line_vld[base + w]) begin
					fill(base + w, tg, it.operation);
					way = w;
					done = 1;
				end else if (line_tg[base + w] == tg) begin
					line_rr[base + w] = RRPV_HIT;
					if (it.operation) line_dt[base + w] = 1;
					hit = 1;
					way = w;
					done = 1;
				end
			end
			if (!done) begin
				for (int r = 0; r < 4 && !done; r++) begin
					for (w = 0; w < nw && !done; w++) begin
						if (line_rr[base + w] == RRPV_MAX) begin
							way = w;
							done = 1;
						end
					end
					if (!done)
						for (w = 0; w < nw; w++)
							if (line_rr[base + w] < RRPV_MAX) line_rr[base + w]++;
				end
				if (line_dt[base + way]) begin
					dev = 1;
					n_dirty_ev = sat_inc(n_dirty_ev);
				end
				fill(base + way, tg, it.operation);
			end
			if (hit) begin
				if (it.operation) n_st_hit = sat_inc(n_st_hit);
				else n_ld_hit = sat_inc(n_ld_hit);
			end else begin
				if (it.operation) n_st_miss = sat_inc(n_st_miss);
				else n_ld_miss = sat_inc(n_ld_miss);
			end
			e.hit = hit;
			e.dirty_eviction = dev;
			e.way_used = way[3:0];
			e.load_hit_count = n_ld_hit;
			e.load_miss_count = n_ld_miss;
			e.store_hit_count = n_st_hit;
			e.store_miss_count = n_st_miss;
			e.dirty_eviction_count = n_dirty_ev;
			expected_q.push_back(e);
		endfunction

		function void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
			if (exp_v !== act_v) begin
				$error("%s: expected %0h, got %0h", name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_result(out_t got);
			out_t e;
			if (expected_q.size() == 0) begin
				$error("result with nothing expected: %h", got);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			checked++;
			cmp("hit", e.hit, got.hit);
			cmp("dirty_eviction", e.dirty_eviction, got.dirty_eviction);
			cmp("way_used", e.way_used, got.way_used);
			cmp("load_hit_count", e.load_hit_count, got.load_hit_count);
			cmp("load_miss_count", e.load_miss_count, got.load_miss_count);
			cmp("store_hit_count", e.store_hit_count, got.store_hit_count);
			cmp("store_miss_count", e.store_miss_count, got.store_miss_count);
			cmp("dirty_eviction_count", e.dirty_eviction_count, got.dirty_eviction_count);
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic push = 0;
	logic full;
	in_t item = '0;
	logic pop = 0;
	logic empty;
	out_t result;
	logic write_enable = 0;
	logic [CFG_INDEX_BITS-1:0] register_index = REG_OFFSET_BITS;
	logic [CFG_DATA_BITS-1:0] write_data = '0;

	lookup_scoreboard sb;
	int hold_cycles = 0;
	bit calm = 0;
	int n_geometries = 0;

	srrip_set_assoc_cache_lookup u_top (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.pop(pop), .empty(empty), .result(result), .write_enable(write_enable),
		.register_index(register_index), .write_data(write_data)
	);

	always #5 clk = ~clk;

	initial begin
		#20_000_000;
		$display("status: fail");
		$finish;
	end

	function int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// result side
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) sb.check_result(result);
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				pop <= 0;
			end else if (calm) begin
				pop <= 1;
			end else begin
				pop <= ($urandom_range(0, 99) < 70);
				if ($urandom_range(0, 199) == 0) hold_cycles <= $urandom_range(10, 40);
			end
		end
	end

	task automatic send_beat(in_t v);
		int g;
		item <= v;
		push <= 1;
		do @(posedge clk); while (full);
		sb.note_access(v);
		g = gap_len();
		if (g > 0) begin
			push <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain();
		push <= 0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic set_geometry(logic [4:0] ob, logic [4:0] ib, logic [4:0] nw);
		write_enable <= 1;
		register_index <= REG_OFFSET_BITS;
		write_data <= ob;
		@(posedge clk);
		sb.write_reg(REG_OFFSET_BITS, ob);
		register_index <= REG_INDEX_BITS;
		write_data <= ib;
		@(posedge clk);
		sb.write_reg(REG_INDEX_BITS, ib);
		register_index <= REG_WAYS_USED;
		write_data <= nw;
		@(posedge clk);
		sb.write_reg(REG_WAYS_USED, nw);
		write_enable <= 0;
		n_geometries++;
	endtask

	function in_t make_access(int unsigned tg, int unsigned set_no);
		in_t v;
		int unsigned ob, ib;
		ob = sb.eff_offset();
		ib = sb.eff_index();
		v.address = (32'(tg) << (ob + ib)) | ((32'(set_no) & ((32'd1 << ib) - 1)) << ob)
			| ($urandom() & ((32'd1 << ob) - 1));
		v.operation = $urandom_range(0, 1);
		return v;
	endfunction

	task automatic random_phase(int n);
		in_t v;
		int unsigned pool;
		pool = sb.eff_ways() + $urandom_range(1, 4);
		repeat (n) begin
			if ($urandom_range(0, 99) < 85)
				v = make_access($urandom_range(0, pool), $urandom_range(0, 3));
			else begin
				v.address = $urandom();
				v.operation = $urandom_range(0, 1);
			end
			send_beat(v);
		end
	endtask

	initial begin
		logic [4:0] geo [8][3];
		in_t v;
		int n_hits;
		geo = '{'{5, 6, 4}, '{0, 0, 1}, '{6, 10, 16}, '{7, 15, 31},
			'{0, 10, 0}, '{3, 2, 8}, '{6, 0, 17}, '{2, 4, 2}};
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1;
		set_geometry(5, 6, 4);

		// directed: extremes, then one set overfilled with mixed loads and stores
		v.address = 32'h0; v.operation = 0; send_beat(v);
		v.address = 32'hFFFF_FFFF; v.operation = 1; send_beat(v);
		v.address = 32'hFFFF_FFFF; v.operation = 0; send_beat(v);
		v.address = 32'h0; v.operation = 1; send_beat(v);
		for (int t = 1; t <= 6; t++) begin
			v = make_access(t, 1); v.operation = t[0]; send_beat(v);
		end
		v = make_access(2, 1); v.operation = 1; send_beat(v);
		v = make_access(3, 1); v.operation = 0; send_beat(v);
		for (int t = 7; t <= 12; t++) begin
			v = make_access(t, 1); send_beat(v);
		end
		drain();

		// long receiver stall so the block backs up
		hold_cycles = 300;
		random_phase(40);
		drain();

		for (int p = 0; p < 8; p++) begin
			set_geometry(geo[p][0], geo[p][1], geo[p][2]);
			calm = (p == 2 || p == 5);
			random_phase(p == 2 ? 60 : 200);
			drain();
			// stale lines under a new split: a random geometry with fresh data
			if (p == 4) begin
				set_geometry($urandom_range(0, 7), $urandom_range(0, 15), $urandom_range(0, 31));
				random_phase(60);
				drain();
			end
		end
		calm = 0;

		n_hits = sb.n_ld_hit + sb.n_st_hit;
		$display("checked %0d lookups over %0d geometries: %0d hits, %0d dirty evictions",
			sb.checked, n_geometries, n_hits, sb.n_dirty_ev);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/srrip_pkg.sv
rtl/srrip_fifo.sv
rtl/srrip_front.sv
rtl/srrip_back.sv
rtl/srrip_set_assoc_cache_lookup.sv
tb/sv/tb_srrip_set_assoc_cache_lookup.sv
